### hdl/scmd_pkg.sv
// Package for the scope command decoder and edge trigger.
// Holds the line buffer sizes, command codes, the command word table and view helpers.
// Depends on nothing.
package scmd_pkg;

    localparam int LINE_BUFFER_LENGTH = 15;
    localparam int LINE_CAPACITY      = LINE_BUFFER_LENGTH - 1;
    localparam int LEN_W              = $clog2(LINE_BUFFER_LENGTH);
    localparam int WORD_COUNT         = 6;
    localparam int BYTE_W             = 8;

    localparam logic [BYTE_W-1:0] LEVEL_RESET  = 8'd188;
    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

    typedef logic [LEN_W-1:0]              len_t;
    typedef logic [BYTE_W-1:0]             byte_t;
    typedef logic [WORD_COUNT-1:0]         word_mask_t;
    typedef logic [8*LINE_CAPACITY-1:0]    word_text_t;

    typedef enum logic [2:0] {
        CMD_INVALID,
        CMD_DISPLAY_SIGNAL,
        CMD_DISPLAY_PDS,
        CMD_TRIGGER_ON,
        CMD_TRIGGER_OFF,
        CMD_TLEVEL_RISE,
        CMD_TLEVEL_FALL
    } cmd_t;

    typedef enum logic [1:0] {
        VIEW_TIME,
        VIEW_SPECTRUM,
        VIEW_TRIGGER
    } view_t;

    // words are right-aligned in the text field
    localparam word_text_t WORD_TEXT [WORD_COUNT] = '{
        word_text_t'("display signal"),
        word_text_t'("display pds"),
        word_text_t'("trigger on"),
        word_text_t'("trigger off"),
        word_text_t'("tlevel rise"),
        word_text_t'("tlevel fall")
    };

    localparam len_t WORD_LEN [WORD_COUNT] = '{
        len_t'(14), len_t'(11), len_t'(10), len_t'(11), len_t'(11), len_t'(11)
    };

    // character idx (from the start) of word k
    function automatic byte_t word_char(input int k, input len_t idx);
        word_text_t t;
        int         base;
        begin
            t    = WORD_TEXT[k] << (8 * (LINE_CAPACITY - int'(WORD_LEN[k])));
            base = 8 * (LINE_CAPACITY - 1 - int'(idx));
            return t[base +: 8];
        end
    endfunction

    function automatic view_t view_of(input logic time_disp, input logic trig_on);
        begin
            if (!time_disp)
                return VIEW_SPECTRUM;
            else if (trig_on)
                return VIEW_TRIGGER;
            else
                return VIEW_TIME;
        end
    endfunction

endpackage

### hdl/scmd_channels.sv
// Request channel interfaces for the scope command decoder and edge trigger.
// Depends on scmd_pkg for the byte width.
interface scmd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [scmd_pkg::BYTE_W-1:0] data_byte;

    modport source(output valid, output mode, output data_byte, input ready);
    modport sink(input valid, input mode, input data_byte, output ready);
endinterface

interface scmd_out_if;
    logic       valid;
    logic       ready;
    logic       line_done;
    logic [2:0] command_code;
    logic       line_overflow;
    logic [1:0] view;
    logic       rising_select;
    logic       trigger_fired;

    modport source(output valid, output line_done, output command_code,
                   output line_overflow, output view, output rising_select,
                   output trigger_fired, input ready);
    modport sink(input valid, input line_done, input command_code,
                 input line_overflow, input view, input rising_select,
                 input trigger_fired, output ready);
endinterface

### hdl/scope_command_and_edge_trigger_core.sv
// Scope command decoder and edge trigger, top level.
// Depends on scmd_pkg and the channel interfaces in scmd_channels.sv.
//
// Usage:
//   in_ch carries requests: mode 0 is a serial character, mode 1 an ADC sample.
//   out_ch returns exactly one result request per input request, in order.
//   cfg_we/cfg_data write the trigger level; write only while the core is idle.
// Sequencing:
//   A sample or a plain character passes from idle through the execute and emit
//   states to the result register; a new request is accepted only after the
//   sequencer has returned to idle. A newline ending a stored line that did not
//   overflow walks it one character per cycle through a single byte compare
//   stage shared by the six command words before the emit state. in_ch.ready is
//   high only while the sequencer is idle.
// Stalls:
//   The result register holds a finished result while out_ch.ready is low; the
//   next request is still accepted and worked on, and waits for the register
//   to free before its result is loaded.
// Reset:
//   Clears the line, selects time view, trigger off, falling edge, and sets the
//   trigger level and the previous sample to 188. No clearing pass is needed.
module scope_command_and_edge_trigger_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    scmd_in_if.sink              in_ch,
    scmd_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  scmd_pkg::byte_t      cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t                 state_reg,     state_next;
    logic                   item_mode_reg, item_mode_next;
    scmd_pkg::byte_t        item_byte_reg, item_byte_next;
    scmd_pkg::len_t         line_len_reg,  line_len_next;
    logic                   too_long_reg,  too_long_next;
    logic                   time_disp_reg, time_disp_next;
    logic                   trig_on_reg,   trig_on_next;
    logic                   rise_reg,      rise_next;
    scmd_pkg::byte_t        prev_reg,      prev_next;
    scmd_pkg::byte_t        level_reg,     level_next;
    scmd_pkg::len_t         idx_reg,       idx_next;
    scmd_pkg::word_mask_t   mask_reg,      mask_next;
    logic                   res_done_reg,  res_done_next;
    scmd_pkg::cmd_t         res_code_reg,  res_code_next;
    logic                   res_ovf_reg,   res_ovf_next;
    logic                   res_fired_reg, res_fired_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_done_reg,  out_done_next;
    scmd_pkg::cmd_t         out_code_reg,  out_code_next;
    logic                   out_ovf_reg,   out_ovf_next;
    scmd_pkg::view_t        out_view_reg,  out_view_next;
    logic                   out_rise_reg,  out_rise_next;
    logic                   out_fired_reg, out_fired_next;

    scmd_pkg::byte_t        line_chars [scmd_pkg::LINE_CAPACITY];
    logic                   char_wr;
    scmd_pkg::byte_t        cur_char;
    scmd_pkg::word_mask_t   hit;
    scmd_pkg::cmd_t         hit_code;
    logic                   scan_last;
    logic                   out_free;

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.line_done     = out_done_reg;
    assign out_ch.command_code  = out_code_reg;
    assign out_ch.line_overflow = out_ovf_reg;
    assign out_ch.view          = out_view_reg;
    assign out_ch.rising_select = out_rise_reg;
    assign out_ch.trigger_fired = out_fired_reg;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign cur_char  = line_chars[idx_reg];
    assign scan_last = (idx_reg == line_len_reg - scmd_pkg::len_t'(1));

    // shared compare stage: one stored character against each surviving word
    always_comb
    begin
        for (int k = 0; k < scmd_pkg::WORD_COUNT; k++)
        begin
            hit[k] = mask_reg[k] && (cur_char == scmd_pkg::word_char(k, idx_reg));
        end
        hit_code = scmd_pkg::CMD_INVALID;
        for (int k = scmd_pkg::WORD_COUNT - 1; k >= 0; k--)
        begin
            if (hit[k])
                hit_code = scmd_pkg::cmd_t'(k + 1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_mode_next = item_mode_reg;
        item_byte_next = item_byte_reg;
        line_len_next  = line_len_reg;
        too_long_next  = too_long_reg;
        time_disp_next = time_disp_reg;
        trig_on_next   = trig_on_reg;
        rise_next      = rise_reg;
        prev_next      = prev_reg;
        level_next     = level_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        res_done_next  = res_done_reg;
        res_code_next  = res_code_reg;
        res_ovf_next   = res_ovf_reg;
        res_fired_next = res_fired_reg;
        out_valid_next = out_valid_reg;
        out_done_next  = out_done_reg;
        out_code_next  = out_code_reg;
        out_ovf_next   = out_ovf_reg;
        out_view_next  = out_view_reg;
        out_rise_next  = out_rise_reg;
        out_fired_next = out_fired_reg;
        char_wr        = 1'b0;

        if (cfg_we)
            level_next = cfg_data;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_mode_next = in_ch.mode;
                    item_byte_next = in_ch.data_byte;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_done_next  = 1'b0;
                res_code_next  = scmd_pkg::CMD_INVALID;
                res_ovf_next   = 1'b0;
                res_fired_next = 1'b0;
                state_next     = S_EMIT;
                if (!item_mode_reg)
                begin
                    if (item_byte_reg == scmd_pkg::NEWLINE_CODE)
                    begin
                        res_done_next = 1'b1;
                        if (too_long_reg || line_len_reg == '0)
                        begin
                            res_ovf_next  = too_long_reg;
                            line_len_next = '0;
                            too_long_next = 1'b0;
                        end
                        else
                        begin
                            for (int k = 0; k < scmd_pkg::WORD_COUNT; k++)
                            begin
                                mask_next[k] = (scmd_pkg::WORD_LEN[k] == line_len_reg);
                            end
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (!too_long_reg)
                    begin
                        if (line_len_reg < scmd_pkg::len_t'(scmd_pkg::LINE_CAPACITY))
                        begin
                            char_wr       = 1'b1;
                            line_len_next = line_len_reg + scmd_pkg::len_t'(1);
                        end
                        else
                        begin
                            too_long_next = 1'b1;
                        end
                    end
                end
                else if (scmd_pkg::view_of(time_disp_reg, trig_on_reg)
                         == scmd_pkg::VIEW_TRIGGER)
                begin
                    if (rise_reg)
                        res_fired_next = (prev_reg < level_reg) && (item_byte_reg > level_reg);
                    else
                        res_fired_next = (prev_reg > level_reg) && (item_byte_reg < level_reg);
                    prev_next = item_byte_reg;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    res_code_next = hit_code;
                    unique case (hit_code)
                        scmd_pkg::CMD_DISPLAY_SIGNAL: time_disp_next = 1'b1;
                        scmd_pkg::CMD_DISPLAY_PDS:    time_disp_next = 1'b0;
                        scmd_pkg::CMD_TRIGGER_ON:     trig_on_next   = 1'b1;
                        scmd_pkg::CMD_TRIGGER_OFF:    trig_on_next   = 1'b0;
                        scmd_pkg::CMD_TLEVEL_RISE:    rise_next      = 1'b1;
                        scmd_pkg::CMD_TLEVEL_FALL:    rise_next      = 1'b0;
                        default:                      ;
                    endcase
                    line_len_next = '0;
                    too_long_next = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    mask_next = hit;
                    idx_next  = idx_reg + scmd_pkg::len_t'(1);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_done_next  = res_done_reg;
                    out_code_next  = res_code_reg;
                    out_ovf_next   = res_ovf_reg;
                    out_view_next  = scmd_pkg::view_of(time_disp_reg, trig_on_reg);
                    out_rise_next  = rise_reg;
                    out_fired_next = res_fired_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            line_len_reg  <= '0;
            too_long_reg  <= 1'b0;
            time_disp_reg <= 1'b1;
            trig_on_reg   <= 1'b0;
            rise_reg      <= 1'b0;
            prev_reg      <= scmd_pkg::LEVEL_RESET;
            level_reg     <= scmd_pkg::LEVEL_RESET;
            idx_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_len_reg  <= line_len_next;
            too_long_reg  <= too_long_next;
            time_disp_reg <= time_disp_next;
            trig_on_reg   <= trig_on_next;
            rise_reg      <= rise_next;
            prev_reg      <= prev_next;
            level_reg     <= level_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_mode_reg <= item_mode_next;
        item_byte_reg <= item_byte_next;
        res_done_reg  <= res_done_next;
        res_code_reg  <= res_code_next;
        res_ovf_reg   <= res_ovf_next;
        res_fired_reg <= res_fired_next;
        out_done_reg  <= out_done_next;
        out_code_reg  <= out_code_next;
        out_ovf_reg   <= out_ovf_next;
        out_view_reg  <= out_view_next;
        out_rise_reg  <= out_rise_next;
        out_fired_reg <= out_fired_next;
        if (char_wr)
            line_chars[line_len_reg] <= item_byte_reg;
    end

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_len_reg <= scmd_pkg::len_t'(scmd_pkg::LINE_CAPACITY))
        else $error("line length beyond capacity");

    a_too_long_full: assert property (@(posedge clk) disable iff (!rst_n)
        too_long_reg |-> line_len_reg == scmd_pkg::len_t'(scmd_pkg::LINE_CAPACITY))
        else $error("overlong flag set on a line that is not full");

    a_one_word_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && scan_last |-> $onehot0(hit))
        else $error("more than one command word matched");

    a_no_code_without_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (!out_done_reg || out_ovf_reg)
            |-> out_code_reg == scmd_pkg::CMD_INVALID)
        else $error("command code on a result without a complete line");

endmodule

### tb/sv/tb_scope_command_and_edge_trigger_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for scope_command_and_edge_trigger_core: command lines and ADC
// samples go in as requests and each result is checked against a local command/trigger model.
// Depends on scmd_pkg, the channel interfaces and the core itself.
module tb_scope_command_and_edge_trigger_core;
    import scmd_pkg::*;

    localparam int MAX_GAP      = 13;
    localparam int PHASES       = 6;
    localparam int PER_PHASE    = 317;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic  mode;
        byte_t data;
    } scope_req_t;

    typedef struct {
        logic  line_done;
        cmd_t  code;
        logic  overflow;
        view_t view;
        logic  rise;
        logic  fired;
    } scope_result_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    byte_t cfg_data;

    scmd_in_if  in_ch();
    scmd_out_if out_ch();

    scope_command_and_edge_trigger_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    scope_req_t    queued_requests[$];
    scope_result_t owed_results[$];

    string cmd_words[WORD_COUNT] = '{"display signal", "display pds", "trigger on",
                                     "trigger off", "tlevel rise", "tlevel fall"};
    cmd_t  word_cmd[WORD_COUNT]  = '{CMD_DISPLAY_SIGNAL, CMD_DISPLAY_PDS, CMD_TRIGGER_ON,
                                     CMD_TRIGGER_OFF, CMD_TLEVEL_RISE, CMD_TLEVEL_FALL};

    // local copy of the core state
    byte_t line_buf[LINE_CAPACITY];
    int    line_len;
    bit    line_long;
    bit    time_disp;
    bit    trig_on;
    bit    rise_sel;
    byte_t prev_level;
    byte_t trig_level;

    int src_gap_max;
    int snk_gap_max;
    int src_wait;
    int snk_wait;
    bit sink_hold;
    bit stall_go;
    int queued_n;
    int fault_count;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic view_t view_now();
        if (!time_disp)
            return VIEW_SPECTRUM;
        return trig_on ? VIEW_TRIGGER : VIEW_TIME;
    endfunction

    function automatic cmd_t match_line();
        cmd_t hit;
        bit   same;
        hit = CMD_INVALID;
        for (int k = 0; k < WORD_COUNT; k++)
        begin
            same = (line_len == cmd_words[k].len());
            for (int i = 0; i < line_len && same; i++)
                if (line_buf[i] != byte_t'(cmd_words[k][i]))
                    same = 1'b0;
            if (same && hit == CMD_INVALID)
                hit = word_cmd[k];
        end
        return hit;
    endfunction

    function automatic scope_result_t decode_and_trigger(input logic md, input byte_t b);
        scope_result_t r;
        r.line_done = 1'b0;
        r.code      = CMD_INVALID;
        r.overflow  = 1'b0;
        r.fired     = 1'b0;
        if (!md)
        begin
            if (b == NEWLINE_CODE)
            begin
                r.line_done = 1'b1;
                if (line_long)
                    r.overflow = 1'b1;
                else
                begin
                    r.code = match_line();
                    case (r.code)
                        CMD_DISPLAY_SIGNAL: time_disp = 1'b1;
                        CMD_DISPLAY_PDS:    time_disp = 1'b0;
                        CMD_TRIGGER_ON:     trig_on   = 1'b1;
                        CMD_TRIGGER_OFF:    trig_on   = 1'b0;
                        CMD_TLEVEL_RISE:    rise_sel  = 1'b1;
                        CMD_TLEVEL_FALL:    rise_sel  = 1'b0;
                        default: ;
                    endcase
                end
                line_len  = 0;
                line_long = 1'b0;
            end
            else if (!line_long)
            begin
                if (line_len < LINE_CAPACITY)
                begin
                    line_buf[line_len] = b;
                    line_len++;
                end
                else
                    line_long = 1'b1;
            end
        end
        else if (view_now() == VIEW_TRIGGER)
        begin
            if (rise_sel)
                r.fired = (prev_level < trig_level) && (b > trig_level);
            else
                r.fired = (prev_level > trig_level) && (b < trig_level);
            prev_level = b;
        end
        r.view = view_now();
        r.rise = rise_sel;
        return r;
    endfunction

    function automatic int draw_gap(input int top);
        return (top == 0) ? 0 : int'($urandom_range(0, top));
    endfunction

    function automatic void note_fault(input string msg);
        if (fault_count < 10)
            $display("%0t: MISMATCH %s", $realtime, msg);
        fault_count++;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        scope_req_t nxt;
        int         gap;
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.mode      <= 1'b0;
            in_ch.data_byte <= '0;
            src_wait        <= 0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid)
            begin
                owed_results.push_back(decode_and_trigger(in_ch.mode, in_ch.data_byte));
                gap = draw_gap(src_gap_max);
            end
            else
                gap = src_wait;
            if (gap == 0 && queued_requests.size() != 0)
            begin
                nxt = queued_requests.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.mode      <= nxt.mode;
                in_ch.data_byte <= nxt.data;
                src_wait        <= 0;
            end
            else
            begin
                in_ch.valid <= 1'b0;
                src_wait    <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        scope_result_t want;
        int            stall;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            snk_wait     <= 0;
        end
        else
        begin
            stall = snk_wait;
            if (out_ch.valid && out_ch.ready)
            begin
                if (owed_results.size() == 0)
                    note_fault($sformatf("unexpected result: done %0b code %0d ovf %0b view %0d",
                                         out_ch.line_done, out_ch.command_code,
                                         out_ch.line_overflow, out_ch.view));
                else
                begin
                    want = owed_results.pop_front();
                    if (out_ch.line_done !== want.line_done || out_ch.command_code !== want.code
                        || out_ch.line_overflow !== want.overflow || out_ch.view !== want.view
                        || out_ch.rising_select !== want.rise
                        || out_ch.trigger_fired !== want.fired)
                        note_fault($sformatf({"exp done %0b code %0d ovf %0b view %0d rise %0b ",
                                              "fired %0b / got %0b %0d %0b %0d %0b %0b"},
                                             want.line_done, want.code, want.overflow,
                                             want.view, want.rise, want.fired,
                                             out_ch.line_done, out_ch.command_code,
                                             out_ch.line_overflow, out_ch.view,
                                             out_ch.rising_select, out_ch.trigger_fired));
                end
                stall = draw_gap(snk_gap_max);
            end
            if (sink_hold)
            begin
                out_ch.ready <= 1'b0;
                snk_wait     <= stall;
            end
            else if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                snk_wait     <= stall - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                snk_wait     <= 0;
            end
        end
    end

    // long receiver hold-off so that the core backs up onto its input
    initial
    begin
        sink_hold = 1'b0;
        wait (stall_go);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_req(input logic md, input byte_t b);
        scope_req_t r;
        r.mode = md;
        r.data = b;
        queued_requests.push_back(r);
        queued_n++;
    endtask

    task automatic push_line(input string w);
        for (int i = 0; i < w.len(); i++)
            push_req(1'b0, byte_t'(w[i]));
        push_req(1'b0, NEWLINE_CODE);
    endtask

    function automatic byte_t rand_char();
        byte_t b;
        do
            b = byte_t'($urandom_range(0, 255));
        while (b == NEWLINE_CODE);
        return b;
    endfunction

    function automatic byte_t rand_level();
        int v;
        case ($urandom_range(0, 3))
            0:
            begin
                v = int'(trig_level) + int'($urandom_range(0, 8)) - 4;
                v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            end
            1:       v = $urandom_range(0, 1) ? 255 : 0;
            default: v = int'($urandom_range(0, 255));
        endcase
        return byte_t'(v);
    endfunction

    task automatic add_unit();
        int    pick;
        int    how;
        int    pos;
        int    n;
        string w;
        pick = $urandom_range(0, 99);
        w    = cmd_words[$urandom_range(0, WORD_COUNT - 1)];
        if (pick < 45)
            push_line(w);
        else if (pick < 55)
        begin
            // damaged command word: replaced, dropped, extra or trailing zero byte
            how = $urandom_range(0, 3);
            pos = $urandom_range(0, w.len() - 1);
            for (int i = 0; i < w.len(); i++)
                if (!(how == 1 && i == w.len() - 1))
                    push_req(1'b0, (how == 0 && i == pos) ? rand_char() : byte_t'(w[i]));
            if (how == 2)
                push_req(1'b0, rand_char());
            if (how == 3)
                push_req(1'b0, 8'h00);
            push_req(1'b0, NEWLINE_CODE);
        end
        else if (pick < 61)
        begin
            n = $urandom_range(LINE_CAPACITY + 1, LINE_CAPACITY + 8);
            repeat (n) push_req(1'b0, rand_char());
            push_req(1'b0, NEWLINE_CODE);
        end
        else if (pick < 66)
        begin
            n = $urandom_range(0, 6);
            repeat (n) push_req(1'b0, byte_t'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 12);
            repeat (n) push_req(1'b1, rand_level());
        end
    endtask

    // checked at the falling edge so that the driver and monitor have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || in_ch.valid || owed_results.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_level(input byte_t v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        trig_level = v;
    endtask

    initial
    begin : stimulus
        byte_t phase_level[PHASES];
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = 1'b0;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;
        stall_go        = 1'b0;
        fault_count     = 0;
        cycle_count     = 0;
        src_gap_max     = MAX_GAP;
        snk_gap_max     = MAX_GAP;
        line_len        = 0;
        line_long       = 1'b0;
        time_disp       = 1'b1;
        trig_on         = 1'b0;
        rise_sel        = 1'b0;
        prev_level      = LEVEL_RESET;
        trig_level      = LEVEL_RESET;
        phase_level     = '{LEVEL_RESET, 8'd0, 8'd255, byte_t'($urandom_range(1, 254)),
                            8'd1, 8'd254};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_level(phase_level[ph]);
            case (ph % 4)
                0: begin src_gap_max = MAX_GAP; snk_gap_max = MAX_GAP; end
                1: begin src_gap_max = 0;       snk_gap_max = 0;       end
                2: begin src_gap_max = MAX_GAP; snk_gap_max = 0;       end
                default: begin src_gap_max = 0; snk_gap_max = MAX_GAP; end
            endcase
            queued_n = 0;
            if (ph == 0)
            begin
                // samples outside trigger view, then falling crossing, empty and junk lines
                push_req(1'b1, 8'hFF);
                push_req(1'b1, 8'h00);
                push_line("trigger on");
                push_req(1'b1, 8'h00);
                push_req(1'b1, 8'hFF);
                push_req(1'b1, 8'h00);
                push_req(1'b0, NEWLINE_CODE);
                push_req(1'b0, 8'hFF);
                push_req(1'b0, 8'h00);
                push_req(1'b0, NEWLINE_CODE);
            end
            while (queued_n < PER_PHASE)
                add_unit();
            if (ph == 1)
                stall_go = 1'b1;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
hdl/scmd_pkg.sv
hdl/scmd_channels.sv
hdl/scope_command_and_edge_trigger_core.sv
tb/sv/tb_scope_command_and_edge_trigger_core.sv
